@@ rtl/blsu_pkg.sv @@
// ----------------------------------------------------------------------------
// blsu_pkg : bounded label set union, shared types and constants
// Entry widths, slot count of the field layout and the structs passed
// between the lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package blsu_pkg;

   localparam int FIELD_SLOTS = 4;   // entry ports per set
   localparam int CNT_W       = 3;   // width of a count field
   localparam int ENTRY_W     = 32;  // width of one label

   typedef logic [ENTRY_W-1:0]                  entry_type;
   typedef logic [FIELD_SLOTS-1:0][ENTRY_W-1:0] entry_vec_type;
   typedef logic [FIELD_SLOTS-1:0]              flag_vec_type;

   // count already clamped to capacity, zero when full
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             full;
   } set_hdr_type;

   typedef struct packed {
      set_hdr_type   hdr;
      entry_vec_type entries;
   } set_type;

endpackage

@@ rtl/blsu_lane.sv @@
// ----------------------------------------------------------------------------
// blsu_lane : membership test for one right-hand entry
// Flags the entry as new when it is valid, absent from the valid left
// entries and not equal to any earlier valid right entry.
// ----------------------------------------------------------------------------
module blsu_lane #(
   parameter int LANE_IDX = 0
) (
   input  blsu_pkg::set_type left_set,
   input  blsu_pkg::set_type right_set,
   output logic              new_flag
);

   logic                 lane_valid;
   logic                 found;
   blsu_pkg::entry_type  mine;

   assign mine       = right_set.entries[LANE_IDX];
   assign lane_valid = blsu_pkg::CNT_W'(LANE_IDX) < right_set.hdr.count;

   always_comb begin
      found = 1'b0;
      for (int j = 0; j < blsu_pkg::FIELD_SLOTS; j++) begin
         if ((blsu_pkg::CNT_W'(j) < left_set.hdr.count) &&
             (left_set.entries[j] == mine)) begin
            found = 1'b1;
         end
         // an earlier right entry is present in the result either way
         if ((j < LANE_IDX) && (right_set.entries[j] == mine)) begin
            found = 1'b1;
         end
      end
   end

   assign new_flag = lane_valid & ~found;

endmodule

@@ rtl/blsu_merge.sv @@
// ----------------------------------------------------------------------------
// blsu_merge : combines lane flags into the result set
// Applies the empty and full rules, then packs the left entries followed by
// the new right entries, saturating to full on overflow.
// ----------------------------------------------------------------------------
module blsu_merge #(
   parameter int SET_SLOTS = 4
) (
   input  blsu_pkg::set_type      left_set,
   input  blsu_pkg::set_type      right_set,
   input  blsu_pkg::flag_vec_type new_flags,
   output blsu_pkg::set_type      result
);

   localparam int TOT_W = blsu_pkg::CNT_W + 1;

   logic                                     left_empty;
   logic                                     right_empty;
   logic [TOT_W-1:0]                         total;
   logic [blsu_pkg::FIELD_SLOTS-1:0][blsu_pkg::CNT_W-1:0] pos;
   blsu_pkg::set_type                        appended;
   logic [blsu_pkg::CNT_W-1:0]               prefix;

   assign left_empty  = ~left_set.hdr.full  & (left_set.hdr.count  == '0);
   assign right_empty = ~right_set.hdr.full & (right_set.hdr.count == '0);

   // slot taken by each new right entry
   always_comb begin
      prefix = left_set.hdr.count;
      for (int i = 0; i < blsu_pkg::FIELD_SLOTS; i++) begin
         pos[i] = prefix;
         if (new_flags[i]) begin
            prefix = prefix + blsu_pkg::CNT_W'(1);
         end
      end
   end

   assign total = TOT_W'(left_set.hdr.count) + TOT_W'($countones(new_flags));

   always_comb begin
      appended = '0;
      if (total > TOT_W'(SET_SLOTS)) begin
         appended.hdr.full = 1'b1;
      end else begin
         appended.hdr.count = blsu_pkg::CNT_W'(total);
         for (int k = 0; k < blsu_pkg::FIELD_SLOTS; k++) begin
            if (blsu_pkg::CNT_W'(k) < left_set.hdr.count) begin
               appended.entries[k] = left_set.entries[k];
            end
            for (int i = 0; i < blsu_pkg::FIELD_SLOTS; i++) begin
               if (new_flags[i] && (pos[i] == blsu_pkg::CNT_W'(k))) begin
                  appended.entries[k] = right_set.entries[i];
               end
            end
         end
      end
   end

   always_comb begin
      if (left_empty) begin
         result = right_set;
      end else if (right_empty) begin
         result = left_set;
      end else if (left_set.hdr.full || right_set.hdr.full) begin
         result          = '0;
         result.hdr.full = 1'b1;
      end else begin
         result = appended;
      end
   end

endmodule

@@ rtl/bounded_label_set_union.sv @@
// ----------------------------------------------------------------------------
// bounded_label_set_union : union of two bounded taint-label sets
// Two-stage pipeline: parallel lanes test each right entry for membership,
// then a merge stage packs the result set and saturates on overflow.
// ----------------------------------------------------------------------------
//
//  channel   ports                       transfer when
//  --------  --------------------------  ---------------------------------
//  request   start, busy, req_*          start high and busy low at edge
//  response  rsp_valid, rsp_*            rsp_valid high (one cycle only)
//
//  One union per clock. A transferred request is registered with its lane
//  flags, then its merged result is registered and shown on the rsp_ ports
//  (two register stages: lane flags, result).
//  busy stays low: neither stage ever holds, and the receiver cannot stall.
//  Synchronous reset clears the stage valid bits only; payload is not reset.
//
module bounded_label_set_union #(
   parameter int SET_SLOTS = 4   // 1..4
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [blsu_pkg::CNT_W-1:0]    req_left_count,
   input  logic                          req_left_full,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_left_entry_0,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_left_entry_1,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_left_entry_2,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_left_entry_3,
   input  logic [blsu_pkg::CNT_W-1:0]    req_right_count,
   input  logic                          req_right_full,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_right_entry_0,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_right_entry_1,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_right_entry_2,
   input  logic [blsu_pkg::ENTRY_W-1:0]  req_right_entry_3,
   // response
   output logic                          rsp_valid,
   output logic [blsu_pkg::CNT_W-1:0]    rsp_union_count,
   output logic                          rsp_union_full,
   output logic [blsu_pkg::ENTRY_W-1:0]  rsp_union_entry_0,
   output logic [blsu_pkg::ENTRY_W-1:0]  rsp_union_entry_1,
   output logic [blsu_pkg::ENTRY_W-1:0]  rsp_union_entry_2,
   output logic [blsu_pkg::ENTRY_W-1:0]  rsp_union_entry_3
);

   localparam logic [blsu_pkg::CNT_W-1:0] CAP = blsu_pkg::CNT_W'(SET_SLOTS);

   logic                   accept;
   blsu_pkg::set_type      left_in,  right_in;
   blsu_pkg::set_type      left_ff,  right_ff;
   blsu_pkg::flag_vec_type new_in,   new_ff;
   logic                   stage_vld_ff;
   blsu_pkg::set_type      merged;
   blsu_pkg::set_type      rsp_in,   rsp_ff;
   logic                   rsp_vld_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // --- normalise incoming sets: clamp count, a full flag wins -------------
   always_comb begin
      left_in             = '0;
      left_in.hdr.full    = req_left_full;
      left_in.entries[0]  = req_left_entry_0;
      left_in.entries[1]  = req_left_entry_1;
      left_in.entries[2]  = req_left_entry_2;
      left_in.entries[3]  = req_left_entry_3;
      if (req_left_full) begin
         left_in.hdr.count = '0;
      end else if (req_left_count > CAP) begin
         left_in.hdr.count = CAP;
      end else begin
         left_in.hdr.count = req_left_count;
      end

      right_in            = '0;
      right_in.hdr.full   = req_right_full;
      right_in.entries[0] = req_right_entry_0;
      right_in.entries[1] = req_right_entry_1;
      right_in.entries[2] = req_right_entry_2;
      right_in.entries[3] = req_right_entry_3;
      if (req_right_full) begin
         right_in.hdr.count = '0;
      end else if (req_right_count > CAP) begin
         right_in.hdr.count = CAP;
      end else begin
         right_in.hdr.count = req_right_count;
      end
   end

   // --- lanes: one membership test per right entry -------------------------
   for (genvar g = 0; g < blsu_pkg::FIELD_SLOTS; g++) begin : g_lane
      blsu_lane #(
         .LANE_IDX (g)
      ) u_lane (
         .left_set  (left_in),
         .right_set (right_in),
         .new_flag  (new_in[g])
      );
   end

   // stage 1: sets and lane flags
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         new_ff   <= new_in;
      end
   end

   // --- merge --------------------------------------------------------------
   blsu_merge #(
      .SET_SLOTS (SET_SLOTS)
   ) u_merge (
      .left_set  (left_ff),
      .right_set (right_ff),
      .new_flags (new_ff),
      .result    (merged)
   );

   // full result carries zero entries; unused slots read zero
   always_comb begin
      rsp_in = merged;
      if (merged.hdr.full) begin
         rsp_in         = '0;
         rsp_in.hdr.full = 1'b1;
      end else begin
         for (int k = 0; k < blsu_pkg::FIELD_SLOTS; k++) begin
            if (blsu_pkg::CNT_W'(k) >= merged.hdr.count) begin
               rsp_in.entries[k] = '0;
            end
         end
      end
   end

   // stage 2: response register, strobe lasts one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= stage_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_union_count   = rsp_ff.hdr.count;
   assign rsp_union_full    = rsp_ff.hdr.full;
   assign rsp_union_entry_0 = rsp_ff.entries[0];
   assign rsp_union_entry_1 = rsp_ff.entries[1];
   assign rsp_union_entry_2 = rsp_ff.entries[2];
   assign rsp_union_entry_3 = rsp_ff.entries[3];

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top : testbench for the bounded label set union
// Drives pairs of label sets through the command port, predicts each union
// independently and checks every response field by field, in order. A short
// directed table covers the rule order, the saturation cases and the field
// extremes; random bursts of mostly well-formed sets with shared labels follow.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 4;       // SET_SLOTS of the instance
   localparam int RAND_ITEMS  = 1900;
   localparam int DRAIN_CYC   = 8;       // two-stage pipe plus margin
   localparam int CYCLE_LIMIT = 200000;

   // one label set as it appears on the ports
   typedef struct packed {
      logic [blsu_pkg::CNT_W-1:0] count;
      logic                       full;
      blsu_pkg::entry_vec_type    ent;
   } label_set_type;

   // directed row: expected union typed in only where it is obvious
   typedef struct packed {
      label_set_type lhs;
      label_set_type rhs;
      logic          known;
      label_set_type want;
   } dir_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   label_set_type              l_set = '0;
   label_set_type              r_set = '0;
   logic                       rsp_valid;
   logic [blsu_pkg::CNT_W-1:0] rsp_union_count;
   logic                       rsp_union_full;
   blsu_pkg::entry_type        rsp_union_entry_0, rsp_union_entry_1;
   blsu_pkg::entry_type        rsp_union_entry_2, rsp_union_entry_3;

   // travels with each request: typed-in expectation for directed rows
   logic                       drv_known = 1'b0;
   label_set_type              drv_want  = '0;

   label_set_type              union_q[$];        // expected unions, oldest first
   dir_row_type                dir_table[$];
   blsu_pkg::entry_type        label_pool[8];     // shared labels so the sets overlap
   int unsigned                mismatch_cnt = 0;
   int unsigned                cycle_cnt    = 0;

   bounded_label_set_union #(.SET_SLOTS(SLOTS)) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_left_count    (l_set.count),
      .req_left_full     (l_set.full),
      .req_left_entry_0  (l_set.ent[0]),
      .req_left_entry_1  (l_set.ent[1]),
      .req_left_entry_2  (l_set.ent[2]),
      .req_left_entry_3  (l_set.ent[3]),
      .req_right_count   (r_set.count),
      .req_right_full    (r_set.full),
      .req_right_entry_0 (r_set.ent[0]),
      .req_right_entry_1 (r_set.ent[1]),
      .req_right_entry_2 (r_set.ent[2]),
      .req_right_entry_3 (r_set.ent[3]),
      .rsp_valid         (rsp_valid),
      .rsp_union_count   (rsp_union_count),
      .rsp_union_full    (rsp_union_full),
      .rsp_union_entry_0 (rsp_union_entry_0),
      .rsp_union_entry_1 (rsp_union_entry_1),
      .rsp_union_entry_2 (rsp_union_entry_2),
      .rsp_union_entry_3 (rsp_union_entry_3)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   function automatic label_set_type mk(int unsigned cnt, bit full,
                                        blsu_pkg::entry_type e0,
                                        blsu_pkg::entry_type e1,
                                        blsu_pkg::entry_type e2,
                                        blsu_pkg::entry_type e3);
      label_set_type s;
      s.count  = cnt[blsu_pkg::CNT_W-1:0];
      s.full   = full;
      s.ent[0] = e0;
      s.ent[1] = e1;
      s.ent[2] = e2;
      s.ent[3] = e3;
      return s;
   endfunction

   // Clamp the count to capacity; a full flag wins over everything else.
   // Slots past the count are cleared so they can be copied straight out.
   function automatic label_set_type normalise_set(label_set_type s);
      label_set_type n;
      n = '0;
      if (s.full) begin
         n.full = 1'b1;
         return n;
      end
      n.count = (s.count > SLOTS) ? blsu_pkg::CNT_W'(SLOTS) : s.count;
      for (int i = 0; i < blsu_pkg::FIELD_SLOTS; i++) begin
         if (i < n.count) n.ent[i] = s.ent[i];
      end
      return n;
   endfunction

   function automatic label_set_type merge_sets(label_set_type lhs,
                                                label_set_type rhs);
      label_set_type a, b, r;
      a = normalise_set(lhs);
      b = normalise_set(rhs);
      if (!a.full && a.count == 0) return b;
      if (!b.full && b.count == 0) return a;
      r = '0;
      if (a.full || b.full) begin
         r.full = 1'b1;
         return r;
      end
      r = a;
      // append each new right label; no room left saturates the union
      for (int i = 0; i < b.count; i++) begin
         bit hit;
         hit = 1'b0;
         for (int j = 0; j < r.count; j++) begin
            if (r.ent[j] == b.ent[i]) hit = 1'b1;
         end
         if (!hit) begin
            if (r.count >= SLOTS) begin
               r      = '0;
               r.full = 1'b1;
               return r;
            end
            r.ent[r.count] = b.ent[i];
            r.count        = r.count + 1'b1;
         end
      end
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Random sets
   // -------------------------------------------------------------------------

   function automatic blsu_pkg::entry_type pick_label();
      if ($urandom_range(0, 9) < 6) return label_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Mostly well-formed sets of 0..4 labels; some saturated, some with an
   // out-of-range count, some with the full flag and a stale count together.
   function automatic label_set_type random_set();
      label_set_type s;
      int unsigned   sel;
      sel     = $urandom_range(0, 99);
      s.full  = (sel < 7) || (sel >= 97 && $urandom_range(0, 1) == 1);
      s.count = (sel >= 88) ? blsu_pkg::CNT_W'($urandom_range(0, 7))
                            : blsu_pkg::CNT_W'($urandom_range(0, SLOTS));
      for (int i = 0; i < blsu_pkg::FIELD_SLOTS; i++) s.ent[i] = pick_label();
      return s;
   endfunction

   task automatic refresh_pool();
      for (int i = 0; i < 8; i++) label_pool[i] = $urandom;
      label_pool[0] = '0;
      label_pool[1] = '1;
   endtask

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------

   // Idle for gap cycles, then present one request and hold it until the
   // transfer. busy is looked at mid-cycle, where it has settled.
   task automatic send_union(int unsigned gap, label_set_type lhs,
                             label_set_type rhs, bit known, label_set_type want);
      bit taken;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      l_set     <= lhs;
      r_set     <= rhs;
      drv_known <= known;
      drv_want  <= want;
      start     <= 1'b1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // hold off until every expected union has come back
   task automatic wait_drained();
      while (union_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      label_set_type nil, sat;
      int unsigned   burst_left;
      int unsigned   gap;

      nil = '0;
      sat = mk(0, 1, 0, 0, 0, 0);

      // rule order: empty left, empty right, either full, then merge
      dir_table.push_back('{mk(0, 0, '1, '1, '1, '1), mk(0, 0, 'h1234, 1, 2, 3), 1'b1, nil});
      dir_table.push_back('{nil, mk(4, 0, 1, 2, 3, 4), 1'b1, mk(4, 0, 1, 2, 3, 4)});
      dir_table.push_back('{mk(2, 0, 'hA, 'hB, 'hDEAD, 'hBEEF), mk(0, 0, 9, 9, 9, 9),
                            1'b1, mk(2, 0, 'hA, 'hB, 0, 0)});
      dir_table.push_back('{mk(1, 1, 5, 0, 0, 0), mk(2, 0, 1, 2, 0, 0), 1'b1, sat});
      dir_table.push_back('{mk(3, 0, 1, 2, 3, 0), mk(0, 1, 0, 0, 0, 0), 1'b1, sat});
      dir_table.push_back('{sat, sat, 1'b1, sat});
      // empty left passes a full right straight through
      dir_table.push_back('{nil, sat, 1'b1, sat});
      // full flag beats a nonzero count
      dir_table.push_back('{mk(3, 1, 7, 8, 9, 0), mk(0, 0, '1, '1, '1, '1), 1'b1, sat});
      // counts above capacity clamp to four
      dir_table.push_back('{mk(7, 0, 1, 2, 3, 4), nil, 1'b1, mk(4, 0, 1, 2, 3, 4)});
      dir_table.push_back('{nil, mk(5, 0, '1, 0, 'h8000_0000, 'h7FFF_FFFF),
                            1'b1, mk(4, 0, '1, 0, 'h8000_0000, 'h7FFF_FFFF)});
      // plain merges, overlap, overflow and duplicates
      dir_table.push_back('{mk(2, 0, 1, 2, 'hFF, 'hFF), mk(2, 0, 2, 3, 'hEE, 'hEE),
                            1'b1, mk(3, 0, 1, 2, 3, 0)});
      dir_table.push_back('{mk(4, 0, 1, 2, 3, 4), mk(1, 0, 5, 0, 0, 0), 1'b1, sat});
      dir_table.push_back('{mk(4, 0, 1, 2, 3, 4), mk(4, 0, 4, 3, 2, 1),
                            1'b1, mk(4, 0, 1, 2, 3, 4)});
      dir_table.push_back('{mk(2, 0, 7, 7, 0, 0), mk(4, 0, 7, 7, 8, 8),
                            1'b1, mk(3, 0, 7, 7, 8, 0)});
      dir_table.push_back('{mk(2, 0, 0, '1, 0, 0), mk(3, 0, '1, 0, 'h8000_0000, 0),
                            1'b1, mk(3, 0, 0, '1, 'h8000_0000, 0)});
      dir_table.push_back('{mk(1, 0, 1, 0, 0, 0), mk(4, 0, 2, 3, 4, 5), 1'b1, sat});
      dir_table.push_back('{mk(3, 0, 1, 2, 3, 0), mk(4, 0, 1, 2, 3, 4),
                            1'b1, mk(4, 0, 1, 2, 3, 4)});
      dir_table.push_back('{mk(3, 0, 4, 4, 4, 0), mk(4, 0, 4, 4, 4, 4),
                            1'b1, mk(3, 0, 4, 4, 4, 0)});
      dir_table.push_back('{mk(3, 0, 1, 2, 3, 0), mk(3, 0, 9, 9, 9, 0),
                            1'b1, mk(4, 0, 1, 2, 3, 9)});
      // predictor rows
      dir_table.push_back('{mk(6, 0, 'h5555_AAAA, 3, 'hFFFF_0000, 1),
                            mk(7, 0, 1, 'h0000_FFFF, 'h5555_AAAA, 8), 1'b0, nil});
      dir_table.push_back('{mk(1, 0, 'h5555_AAAA, 0, 0, 0),
                            mk(3, 0, 'hAAAA_5555, 'h5555_AAAA, 'h0F0F_0F0F, 0), 1'b0, nil});
      dir_table.push_back('{mk(5, 1, 1, 2, 3, 4), mk(6, 1, 5, 6, 7, 8), 1'b0, nil});
      dir_table.push_back('{mk(2, 0, 'hF0F0_F0F0, 'h0F0F_0F0F, 0, 0),
                            mk(2, 0, 'h0F0F_0F0F, 'hF0F0_F0F0, 0, 0), 1'b0, nil});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_table[i]) begin
         send_union($urandom_range(0, 2), dir_table[i].lhs, dir_table[i].rhs,
                    dir_table[i].known, dir_table[i].want);
      end

      // pause with the pipe empty before the random part
      start <= 1'b0;
      wait_drained();

      refresh_pool();
      burst_left = 0;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         gap = 0;
         if (burst_left == 0) begin
            // long unbroken stretches now and then, short ones otherwise; a short gap before each
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            gap        = $urandom_range(1, 7);
         end
         burst_left--;
         if (n % 200 == 199) refresh_pool();
         send_union(gap, random_set(), random_set(), 1'b0, nil);
         if (n == RAND_ITEMS / 2) begin
            start <= 1'b0;
            wait_drained();
         end
      end
      start <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYC) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Monitor: both channels are looked at mid-cycle, where every port has
   // settled; a request seen with start high and busy low transfers at the
   // next rising edge, as does any response marked by rsp_valid.
   // -------------------------------------------------------------------------

   task automatic check_field(string name, logic [blsu_pkg::ENTRY_W-1:0] want,
                              logic [blsu_pkg::ENTRY_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_cnt++;
      end
   endtask

   always @(negedge clock) begin
      label_set_type want;
      if (!reset && start && !busy) begin
         union_q.push_back(drv_known ? drv_want : merge_sets(l_set, r_set));
      end
      if (!reset && rsp_valid) begin
         if (union_q.size() == 0) begin
            $error("union response with nothing outstanding");
            mismatch_cnt++;
         end else begin
            want = union_q.pop_front();
            check_field("union_count", blsu_pkg::ENTRY_W'(want.count),
                        blsu_pkg::ENTRY_W'(rsp_union_count));
            check_field("union_full", blsu_pkg::ENTRY_W'(want.full),
                        blsu_pkg::ENTRY_W'(rsp_union_full));
            check_field("union_entry_0", want.ent[0], rsp_union_entry_0);
            check_field("union_entry_1", want.ent[1], rsp_union_entry_1);
            check_field("union_entry_2", want.ent[2], rsp_union_entry_2);
            check_field("union_entry_3", want.ent[3], rsp_union_entry_3);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
